// ===== sv/tlik_pkg.sv =====
package tlik_pkg;

  // Square root operand and root widths (operand is value << (46 - 2*FRAC_BITS)).
  localparam int OP_W     = 60;
  localparam int SQ_STEPS = OP_W / 2;
  localparam int ROOT_W   = SQ_STEPS;

  // Vectoring-mode arctangent: 23 micro-rotations plus a clamp stage.
  localparam int CD_STEPS = 23;
  localparam int CD_LAT   = CD_STEPS + 1;
  localparam int BK_LAT   = SQ_STEPS + CD_LAT;

  // Angles in units of 2^-16 degree.
  localparam logic [22:0] DEG90 = 23'd5898240;

  // pulse = floor(angle * 449 / 180) + 1, as angle * (449 * ceil(2^24 / 180)) >> 24.
  localparam logic [25:0] PULSE_MUL = 26'd41849943;

  localparam int QDEPTH = 4;
  localparam int ODEPTH = 4;

  // Configuration register indexes.
  localparam logic [7:0] CFG_LINK_LENGTH = 8'd0;
  localparam logic [7:0] CFG_KNEE_MIN    = 8'd1;
  localparam logic [7:0] CFG_FEMUR_MAX   = 8'd2;
  localparam logic [7:0] CFG_HIP_MID     = 8'd3;

  localparam logic [5:0]  RST_LINK_LENGTH = 6'd10;
  localparam logic [31:0] RST_KNEE_MIN    = 32'd808;
  localparam logic [31:0] RST_FEMUR_MAX   = 32'd2694219670;
  localparam logic [31:0] RST_HIP_MID     = 32'd1515539235;

  typedef enum logic [2:0] {
    JOINT_KNEE  = 3'b001,
    JOINT_FEMUR = 3'b010,
    JOINT_HIP   = 3'b100
  } joint_t;

  typedef struct packed {
    logic [1:0]  leg;
    logic [7:0]  knee_trim;
    logic [7:0]  femur_max;
    logic [7:0]  hip_mid;
    logic        reach_zero;
    logic        reach_over;
    logic        h_zero;
    logic        x_pos;
    logic        x_neg;
    logic        sign_diff;
    logic [15:0] ah;
    logic [15:0] ax;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [OP_W-1:0]  op_a;
    logic [OP_W-1:0]  op_b;
  } desc_t;

  typedef struct packed {
    logic [3:0] servo_channel;
    logic [8:0] pulse_value;
    logic       last_of_leg;
  } result_t;

  // atan(2^-i) in 2^-16 degree units, one radian taken as 57.296 degrees.
  function automatic logic [21:0] atan_entry(input int i);
    logic [21:0] v;
    unique case (i)
      0:  v = 22'd2949131;
      1:  v = 22'd1740974;
      2:  v = 22'd919883;
      3:  v = 22'd466947;
      4:  v = 22'd234380;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      20: v = 22'd4;
      21: v = 22'd2;
      22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/tlik_front.sv =====
module tlik_front #(
  parameter int NUM_LEGS  = 4,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           leg_number,
  input  logic signed [15:0]   foot_height,
  input  logic signed [15:0]   forward_offset,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [2:0]           q_count,
  output logic                 desc_push,
  output tlik_pkg::desc_t      desc
);

  localparam int WW = 14 + 2 * FRAC_BITS;
  localparam int UW = (WW > 32) ? WW : 32;
  localparam int SH = 46 - 2 * FRAC_BITS;

  logic [5:0]  link_length;
  logic [31:0] knee_min_pack;
  logic [31:0] femur_max_pack;
  logic [31:0] hip_mid_pack;

  logic               accept;
  logic               s1v;
  logic [1:0]         s1_leg;
  logic signed [15:0] s1_h;
  logic signed [15:0] s1_x;
  logic [7:0]         s1_knee;
  logic [7:0]         s1_femur;
  logic [7:0]         s1_hip;

  logic               s2v;
  logic [1:0]         s2_leg;
  logic signed [15:0] s2_h;
  logic signed [15:0] s2_x;
  logic [7:0]         s2_knee;
  logic [7:0]         s2_femur;
  logic [7:0]         s2_hip;
  logic [31:0]        s2_hh;
  logic [31:0]        s2_xx;
  logic [11:0]        s2_ll;

  logic signed [31:0] hh_p;
  logic signed [31:0] xx_p;
  logic [31:0]        u;
  logic [WW-1:0]      w;
  logic [UW-1:0]      u_ext;
  logic [UW-1:0]      w_ext;
  logic [UW-1:0]      wmu;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_length    <= tlik_pkg::RST_LINK_LENGTH;
      knee_min_pack  <= tlik_pkg::RST_KNEE_MIN;
      femur_max_pack <= tlik_pkg::RST_FEMUR_MAX;
      hip_mid_pack   <= tlik_pkg::RST_HIP_MID;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tlik_pkg::CFG_LINK_LENGTH: link_length    <= cfg_data[5:0];
        tlik_pkg::CFG_KNEE_MIN:    knee_min_pack  <= cfg_data;
        tlik_pkg::CFG_FEMUR_MAX:   femur_max_pack <= cfg_data;
        tlik_pkg::CFG_HIP_MID:     hip_mid_pack   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Count every target in flight here against the queue room.
  assign full   = (4'(q_count) + 4'(s1v) + 4'(s2v)) >= 4'(tlik_pkg::QDEPTH);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
    end else begin
      s1v <= accept;
      s2v <= s1v;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_leg   <= leg_number;
      s1_h     <= foot_height;
      s1_x     <= forward_offset;
      s1_knee  <= knee_min_pack[{leg_number, 3'b000} +: 8];
      s1_femur <= femur_max_pack[{leg_number, 3'b000} +: 8];
      s1_hip   <= hip_mid_pack[{leg_number, 3'b000} +: 8];
    end
  end

  assign hh_p = s1_h * s1_h;
  assign xx_p = s1_x * s1_x;

  always_ff @(posedge clk) begin
    s2_leg   <= s1_leg;
    s2_h     <= s1_h;
    s2_x     <= s1_x;
    s2_knee  <= s1_knee;
    s2_femur <= s1_femur;
    s2_hip   <= s1_hip;
    s2_hh    <= hh_p;
    s2_xx    <= xx_p;
    s2_ll    <= 12'(link_length * link_length);
  end

  // Squared reach against (2L)^2, both with 2*FRAC_BITS fraction bits.
  assign u     = s2_hh + s2_xx;
  assign w     = WW'({s2_ll, 2'b00}) << (2 * FRAC_BITS);
  assign u_ext = UW'(u);
  assign w_ext = UW'(w);
  assign wmu   = w_ext - u_ext;

  assign desc_push = s2v && ({1'b0, s2_leg} < 3'(NUM_LEGS));

  always_comb begin
    desc.side.leg        = s2_leg;
    desc.side.knee_trim  = s2_knee;
    desc.side.femur_max  = s2_femur;
    desc.side.hip_mid    = s2_hip;
    desc.side.reach_zero = (u == 32'd0);
    desc.side.reach_over = (u_ext >= w_ext);
    desc.side.h_zero     = (s2_h == 16'sd0);
    desc.side.x_pos      = !s2_x[15] && (s2_x != 16'sd0);
    desc.side.x_neg      = s2_x[15];
    desc.side.sign_diff  = s2_x[15] != s2_h[15];
    desc.side.ah         = s2_h[15] ? 16'(-s2_h) : 16'(s2_h);
    desc.side.ax         = s2_x[15] ? 16'(-s2_x) : 16'(s2_x);
    desc.op_a            = tlik_pkg::OP_W'(u) << SH;
    desc.op_b            = tlik_pkg::OP_W'(wmu) << SH;
  end

endmodule

// ===== sv/tlik_queue.sv =====
module tlik_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  tlik_pkg::desc_t  din,
  input  logic             rd,
  output tlik_pkg::desc_t  dout,
  output logic             valid,
  output logic [2:0]       count
);

  localparam int PW = $clog2(tlik_pkg::QDEPTH);

  tlik_pkg::desc_t entries [tlik_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + PW'(1);
      if (rd) rd_ptr <= rd_ptr + PW'(1);
      count <= count + 3'(wr) - 3'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) entries[wr_ptr] <= din;
  end

  assign dout  = entries[rd_ptr];
  assign valid = (count != 3'd0);

endmodule

// ===== sv/tlik_sqrt.sv =====
module tlik_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tlik_pkg::OP_W-1:0]     op,
  output logic [tlik_pkg::ROOT_W-1:0]   root
);

  localparam int N  = tlik_pkg::SQ_STEPS;
  localparam int RB = tlik_pkg::ROOT_W;
  localparam int RW = RB + 2;
  localparam int OW = tlik_pkg::OP_W;

  logic [RW-1:0] rem_q  [N];
  logic [RB-1:0] root_q [N];
  logic [OW-1:0] op_q   [N-1];

  logic [RW-1:0]   rem_in  [N];
  logic [RB-1:0]   root_in [N];
  logic [OW-1:0]   op_in   [N];
  logic [RW+1:0]   rem_s   [N];
  logic [RW+1:0]   trial   [N];
  logic            ge      [N];

  // One root bit per stage, two operand bits brought down each time.
  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    op_in[0]   = op;
    for (int k = 1; k < N; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      op_in[k]   = op_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      rem_s[k] = {rem_in[k], op_in[k][OW-1 -: 2]};
      trial[k] = {2'b00, root_in[k], 2'b01};
      ge[k]    = rem_s[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k]  <= ge[k] ? RW'(rem_s[k] - trial[k]) : RW'(rem_s[k]);
        root_q[k] <= {root_in[k][RB-2:0], ge[k]};
        if (k < N - 1) op_q[k] <= op_in[k] << 2;
      end
    end
  end

  assign root = root_q[N-1];

endmodule

// ===== sv/tlik_cordic.sv =====
module tlik_cordic (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tlik_pkg::ROOT_W-1:0]   xa,
  input  logic [tlik_pkg::ROOT_W-1:0]   ya,
  output logic [22:0]                   z
);

  localparam int N  = tlik_pkg::CD_STEPS;
  localparam int XW = tlik_pkg::ROOT_W + 4;
  localparam int ZW = 25;

  logic signed [XW-1:0] xv [N];
  logic signed [XW-1:0] yv [N];
  logic signed [ZW-1:0] zv [N];
  logic                 yz [N];
  logic                 xz [N];

  logic signed [XW-1:0] x_in [N];
  logic signed [XW-1:0] y_in [N];
  logic signed [ZW-1:0] z_in [N];
  logic                 yz_in [N];
  logic                 xz_in [N];
  logic                 y_pos [N];
  logic signed [ZW-1:0] z_last;

  always_comb begin
    x_in[0]  = $signed({{(XW - tlik_pkg::ROOT_W){1'b0}}, xa});
    y_in[0]  = $signed({{(XW - tlik_pkg::ROOT_W){1'b0}}, ya});
    z_in[0]  = '0;
    yz_in[0] = (ya == '0);
    xz_in[0] = (xa == '0);
    for (int i = 1; i < N; i++) begin
      x_in[i]  = xv[i-1];
      y_in[i]  = yv[i-1];
      z_in[i]  = zv[i-1];
      yz_in[i] = yz[i-1];
      xz_in[i] = xz[i-1];
    end
    for (int i = 0; i < N; i++) begin
      y_pos[i] = !y_in[i][XW-1] && (y_in[i] != '0);
    end
  end

  // Rotate toward the x axis; shifts floor like the arithmetic shift.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        yz[i] <= yz_in[i];
        xz[i] <= xz_in[i];
        if (y_pos[i]) begin
          xv[i] <= x_in[i] + (y_in[i] >>> i);
          yv[i] <= y_in[i] - (x_in[i] >>> i);
          zv[i] <= z_in[i] + $signed(ZW'(tlik_pkg::atan_entry(i)));
        end else begin
          xv[i] <= x_in[i] - (y_in[i] >>> i);
          yv[i] <= y_in[i] + (x_in[i] >>> i);
          zv[i] <= z_in[i] - $signed(ZW'(tlik_pkg::atan_entry(i)));
        end
      end
    end
  end

  assign z_last = zv[N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (yz[N-1]) z <= '0;
      else if (xz[N-1]) z <= tlik_pkg::DEG90;
      else if (z_last[ZW-1]) z <= '0;
      else if (z_last > $signed({2'b00, tlik_pkg::DEG90})) z <= tlik_pkg::DEG90;
      else z <= z_last[22:0];
    end
  end

endmodule

// ===== sv/tlik_back.sv =====
module tlik_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  tlik_pkg::desc_t     q_head,
  output logic                q_pop,
  input  logic                out_full,
  output logic                res_write,
  output tlik_pkg::result_t   res
);

  localparam int SQ = tlik_pkg::SQ_STEPS;
  localparam int BL = tlik_pkg::BK_LAT;

  logic                          adv;
  logic                          ser_take;
  logic [BL-1:0]                 vld;
  tlik_pkg::side_t               side [BL];
  tlik_pkg::side_t               s;

  logic [tlik_pkg::ROOT_W-1:0]   ra;
  logic [tlik_pkg::ROOT_W-1:0]   rb;
  logic [tlik_pkg::ROOT_W-1:0]   lean_x;
  logic [tlik_pkg::ROOT_W-1:0]   lean_y;
  logic [22:0]                   zk;
  logic [22:0]                   zf;
  logic [22:0]                   zl;

  logic [7:0]                    knee_ang;
  logic [6:0]                    fc;
  logic signed [24:0]            th;
  logic signed [24:0]            ft;
  logic [24:0]                   nft;
  logic signed [8:0]             ft_deg;
  logic [9:0]                    knee_sum;
  logic signed [10:0]            femur_sum;
  logic [7:0]                    ang_next [3];

  logic                          f1v;
  logic [1:0]                    f1_leg;
  logic [7:0]                    f1_ang [3];
  logic [33:0]                   prod [3];
  logic                          f2v;
  logic [1:0]                    f2_leg;
  logic [8:0]                    f2_pulse [3];

  logic                          busy;
  tlik_pkg::joint_t              jnt;
  logic [1:0]                    s_leg;
  logic [8:0]                    s_pulse [3];
  logic [3:0]                    jidx;
  logic [8:0]                    jpulse;

  assign ser_take = !busy || (jnt == tlik_pkg::JOINT_HIP && !out_full);
  assign adv      = !f2v || ser_take;
  assign q_pop    = adv && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      f1v <= 1'b0;
      f2v <= 1'b0;
    end else if (adv) begin
      vld <= {vld[BL-2:0], q_pop};
      f1v <= vld[BL-1];
      f2v <= f1v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= q_head.side;
      for (int k = 1; k < BL; k++) side[k] <= side[k-1];
    end
  end

  tlik_sqrt u_sqrt_a (.clk(clk), .en(adv), .op(q_head.op_a), .root(ra));
  tlik_sqrt u_sqrt_b (.clk(clk), .en(adv), .op(q_head.op_b), .root(rb));

  assign lean_x = {side[SQ-1].ah, 14'b0};
  assign lean_y = {side[SQ-1].ax, 14'b0};

  tlik_cordic u_cd_knee  (.clk(clk), .en(adv), .xa(rb),     .ya(ra),     .z(zk));
  tlik_cordic u_cd_femur (.clk(clk), .en(adv), .xa(ra),     .ya(rb),     .z(zf));
  tlik_cordic u_cd_lean  (.clk(clk), .en(adv), .xa(lean_x), .ya(lean_y), .z(zl));

  assign s = side[BL-1];

  // Joint angles in whole degrees: knee trim added, femur taken off femur_max, hip from hip_mid; saturated to 0..180.
  always_comb begin
    priority if (s.reach_zero) knee_ang = 8'd0;
    else if (s.reach_over) knee_ang = 8'd180;
    else knee_ang = zk[22:15];
    fc = (s.reach_zero || s.reach_over) ? 7'd0 : zf[22:16];

    priority if (s.h_zero && s.x_pos) th = $signed({2'b00, tlik_pkg::DEG90});
    else if (s.h_zero && s.x_neg) th = -$signed({2'b00, tlik_pkg::DEG90});
    else if (s.h_zero) th = '0;
    else if (s.sign_diff) th = -$signed({2'b00, zl});
    else th = $signed({2'b00, zl});

    ft  = $signed({2'b00, 7'd90 - fc, 16'b0}) + th;
    nft = 25'(-ft);
    ft_deg = ft[24] ? -$signed({1'b0, nft[23:16]}) : $signed({1'b0, ft[23:16]});

    knee_sum  = 10'(s.knee_trim) + 10'(knee_ang);
    femur_sum = $signed({3'b000, s.femur_max}) - $signed({{2{ft_deg[8]}}, ft_deg});

    ang_next[0] = (knee_sum > 10'd180) ? 8'd180 : knee_sum[7:0];
    priority if (femur_sum[10]) ang_next[1] = 8'd0;
    else if (femur_sum > 11'sd180) ang_next[1] = 8'd180;
    else ang_next[1] = femur_sum[7:0];
    ang_next[2] = (s.hip_mid > 8'd180) ? 8'd180 : s.hip_mid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_leg <= s.leg;
      f2_leg <= f1_leg;
      for (int j = 0; j < 3; j++) begin
        f1_ang[j]   <= ang_next[j];
        f2_pulse[j] <= 9'(prod[j][33:24]) + 9'd1;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod[j] = 34'(f1_ang[j]) * 34'(tlik_pkg::PULSE_MUL);
    end
  end

  // Hand out knee, femur, hip one per cycle while the result queue is not full.
  assign res_write = busy && !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      jnt  <= tlik_pkg::JOINT_KNEE;
    end else begin
      if (adv && f2v) begin
        busy <= 1'b1;
        jnt  <= tlik_pkg::JOINT_KNEE;
      end else if (res_write) begin
        unique case (jnt)
          tlik_pkg::JOINT_KNEE:  jnt <= tlik_pkg::JOINT_FEMUR;
          tlik_pkg::JOINT_FEMUR: jnt <= tlik_pkg::JOINT_HIP;
          tlik_pkg::JOINT_HIP: begin
            jnt  <= tlik_pkg::JOINT_KNEE;
            busy <= 1'b0;
          end
          default: jnt <= tlik_pkg::JOINT_KNEE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && f2v) begin
      s_leg <= f2_leg;
      for (int j = 0; j < 3; j++) s_pulse[j] <= f2_pulse[j];
    end
  end

  always_comb begin
    unique case (jnt)
      tlik_pkg::JOINT_KNEE: begin
        jidx   = 4'd0;
        jpulse = s_pulse[0];
      end
      tlik_pkg::JOINT_FEMUR: begin
        jidx   = 4'd1;
        jpulse = s_pulse[1];
      end
      tlik_pkg::JOINT_HIP: begin
        jidx   = 4'd2;
        jpulse = s_pulse[2];
      end
      default: begin
        jidx   = 4'd0;
        jpulse = s_pulse[0];
      end
    endcase
  end

  assign res.servo_channel = 4'({s_leg, 1'b0}) + 4'(s_leg) + jidx;
  assign res.pulse_value   = jpulse;
  assign res.last_of_leg   = (jnt == tlik_pkg::JOINT_HIP);

endmodule

// ===== sv/two_link_leg_inverse_kinematics.sv =====
// Two-link leg inverse kinematics. Push a leg number and a foot target
// (height and forward offset, signed fixed point with FRAC_BITS fraction
// bits); pop three servo results in order knee, femur, hip, the hip one
// flagged by last_of_leg. A target for a leg at or above NUM_LEGS is taken
// and dropped without results. Targets enter a four-entry queue at one per
// cycle while full is low; the back end hands out each target's three
// results one per cycle while the result queue has room, and takes new
// targets before earlier ones are out. Stages: two front, 30 square-root
// (one root bit each), 24 arctangent, two angle and pulse, then the result
// queue. Configuration is taken at any cycle on the cfg channel (ready is
// always high) and should be written only while no target is in flight.
module two_link_leg_inverse_kinematics #(
  parameter int NUM_LEGS  = 4,
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         leg_number,
  input  logic signed [15:0] foot_height,
  input  logic signed [15:0] forward_offset,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         servo_channel,
  output logic [8:0]         pulse_value,
  output logic               last_of_leg,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int OPW = $clog2(tlik_pkg::ODEPTH);

  logic               desc_push;
  tlik_pkg::desc_t    desc_in;
  tlik_pkg::desc_t    desc_head;
  logic               desc_valid;
  logic               desc_pop;
  logic [2:0]         q_count;

  logic               res_write;
  tlik_pkg::result_t  res;
  logic               out_full;

  tlik_pkg::result_t  obuf [tlik_pkg::ODEPTH];
  logic [OPW-1:0]     o_wr;
  logic [OPW-1:0]     o_rd;
  logic [2:0]         o_count;
  logic               o_pop;

  // Front: take transactions, square and classify the reach.
  tlik_front #(
    .NUM_LEGS (NUM_LEGS),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .leg_number    (leg_number),
    .foot_height   (foot_height),
    .forward_offset(forward_offset),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_count       (q_count),
    .desc_push     (desc_push),
    .desc          (desc_in)
  );

  // Decouple front from back so each can stall on its own.
  tlik_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (desc_push),
    .din  (desc_in),
    .rd   (desc_pop),
    .dout (desc_head),
    .valid(desc_valid),
    .count(q_count)
  );

  // Back: roots, arctangents, angles, pulses, then one result per cycle while the result queue has room.
  tlik_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (desc_valid),
    .q_head   (desc_head),
    .q_pop    (desc_pop),
    .out_full (out_full),
    .res_write(res_write),
    .res      (res)
  );

  // Result queue: hold finished results until the consumer pops them.
  assign out_full = (o_count == 3'(tlik_pkg::ODEPTH));
  assign empty    = (o_count == 3'd0);
  assign o_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= '0;
      o_rd    <= '0;
      o_count <= '0;
    end else begin
      if (res_write) o_wr <= o_wr + OPW'(1);
      if (o_pop) o_rd <= o_rd + OPW'(1);
      o_count <= o_count + 3'(res_write) - 3'(o_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) obuf[o_wr] <= res;
  end

  assign servo_channel = obuf[o_rd].servo_channel;
  assign pulse_value   = obuf[o_rd].pulse_value;
  assign last_of_leg   = obuf[o_rd].last_of_leg;

`ifndef SYNTHESIS
  a_no_result_overflow: assert property (@(posedge clk) disable iff (rst)
    res_write |-> !out_full)
    else $error("result written into a full result queue");

  a_no_desc_overflow: assert property (@(posedge clk) disable iff (rst)
    desc_push |-> (q_count < 3'(tlik_pkg::QDEPTH)) || desc_pop)
    else $error("target pushed into a full queue");

  a_hip_channel: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_of_leg) |-> (servo_channel == 4'd2 || servo_channel == 4'd5 ||
                                 servo_channel == 4'd8 || servo_channel == 4'd11))
    else $error("last result of a leg is not a hip channel");

  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pulse_value >= 9'd1) && (pulse_value <= 9'd450))
    else $error("pulse out of range");
`endif

endmodule

// ===== tb/sv/two_link_leg_inverse_kinematics_test.sv =====
module two_link_leg_inverse_kinematics_test;

  typedef struct {
    logic [3:0] servo_channel;
    logic [8:0] pulse_value;
    logic       last_of_leg;
  } servo_cmd_t;

  // Predicts the servo commands for each accepted foot target and checks
  // popped commands against them in order.
  class servo_scoreboard;
    logic [5:0]  link_len;
    logic [31:0] knee_trims;
    logic [31:0] femur_maxes;
    logic [31:0] hip_mids;
    servo_cmd_t  pending[$];
    int          mismatches;

    function new();
      link_len    = tlik_pkg::RST_LINK_LENGTH;
      knee_trims  = tlik_pkg::RST_KNEE_MIN;
      femur_maxes = tlik_pkg::RST_FEMUR_MAX;
      hip_mids    = tlik_pkg::RST_HIP_MID;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] val);
      case (idx)
        tlik_pkg::CFG_LINK_LENGTH: link_len    = val[5:0];
        tlik_pkg::CFG_KNEE_MIN:    knee_trims  = val;
        tlik_pkg::CFG_FEMUR_MAX:   femur_maxes = val;
        tlik_pkg::CFG_HIP_MID:     hip_mids    = val;
        default: ;
      endcase
    endfunction

    static function longint floor_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Vectoring arctangent of ya/xa, 2^-16 degree units, clamped to 0..90.
    static function longint vector_angle(longint xa, longint ya);
      longint xv, yv, z, xs, ys;
      xv = xa;
      yv = ya;
      z = 0;
      if (ya == 0) return 0;
      if (xa == 0) return 64'sd90 * 65536;
      for (int i = 0; i < tlik_pkg::CD_STEPS; i++) begin
        xs = xv >>> i;
        ys = yv >>> i;
        if (yv > 0) begin
          xv = xv + ys;
          yv = yv - xs;
          z = z + longint'(tlik_pkg::atan_entry(i));
        end else begin
          xv = xv - ys;
          yv = yv + xs;
          z = z - longint'(tlik_pkg::atan_entry(i));
        end
      end
      if (z < 0) z = 0;
      if (z > 64'sd90 * 65536) z = 64'sd90 * 65536;
      return z;
    endfunction

    static function logic [8:0] angle_to_pulse(longint a);
      if (a < 0) a = 0;
      if (a > 180) a = 180;
      return 9'(a * 449 / 180 + 1);
    endfunction

    // Note one accepted foot target and queue its three commands.
    function void note_target(logic [1:0] leg, logic signed [15:0] fh,
                              logic signed [15:0] fx);
      longint h, x, knee, fc, lean, ft, ft_deg, a, b;
      longint unsigned u, w;
      longint ang[3];
      servo_cmd_t c;
      if (leg >= 4) return;
      h = fh;
      x = fx;
      u = h * h + x * x;
      w = (64'd4 * link_len * link_len) << 16;
      if (u == 0) begin
        knee = 0;
        fc = 0;
      end else if (u >= w) begin
        knee = 180;
        fc = 0;
      end else begin
        a = floor_sqrt(u << 30);
        b = floor_sqrt((w - u) << 30);
        knee = (2 * vector_angle(b, a)) >>> 16;
        fc = vector_angle(a, b) >>> 16;
      end
      if (h == 0) begin
        lean = x > 0 ? 64'sd90 * 65536 : (x < 0 ? -64'sd90 * 65536 : 0);
      end else begin
        lean = vector_angle((h < 0 ? -h : h) << 14, (x < 0 ? -x : x) << 14);
        if ((x < 0) != (h < 0)) lean = -lean;
      end
      ft = (90 - fc) * 65536 + lean;
      ft_deg = ft >= 0 ? (ft >>> 16) : -((-ft) >>> 16);
      ang[0] = longint'(knee_trims[8*leg +: 8]) + knee;
      ang[1] = longint'(femur_maxes[8*leg +: 8]) - ft_deg;
      ang[2] = longint'(hip_mids[8*leg +: 8]);
      for (int j = 0; j < 3; j++) begin
        c.servo_channel = 4'(3 * leg + j);
        c.pulse_value   = angle_to_pulse(ang[j]);
        c.last_of_leg   = (j == 2);
        pending.push_back(c);
      end
    endfunction

    function void check_cmd(logic [3:0] ch, logic [8:0] pv, logic lst);
      servo_cmd_t e;
      if (pending.size() == 0) begin
        $error("unexpected servo command ch=%0d pulse=%0d", ch, pv);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      if (ch !== e.servo_channel) begin
        $error("servo_channel expected %0d actual %0d", e.servo_channel, ch);
        mismatches++;
      end
      if (pv !== e.pulse_value) begin
        $error("pulse_value expected %0d actual %0d", e.pulse_value, pv);
        mismatches++;
      end
      if (lst !== e.last_of_leg) begin
        $error("last_of_leg expected %0d actual %0d", e.last_of_leg, lst);
        mismatches++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  logic [1:0] leg_number = 0;
  logic signed [15:0] foot_height = 0;
  logic signed [15:0] forward_offset = 0;
  logic empty;
  logic pop = 0;
  logic [3:0] servo_channel;
  logic [8:0] pulse_value;
  logic last_of_leg;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [7:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  servo_scoreboard board = new();
  bit steady = 0;        // no idling on either side while set
  int idle_cycles = 0;   // cycles since the last transaction
  int targets_sent = 0;
  int cmds_seen = 0;

  two_link_leg_inverse_kinematics uut (.*);

  always #5 clk = ~clk;

  // Result side: pop at random (always while steady), check every popped command at the edge.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      board.check_cmd(servo_channel, pulse_value, last_of_leg);
      cmds_seen++;
    end
  end

  always @(negedge clk) begin
    pop <= steady ? 1'b1 : ($urandom_range(99) >= 20);
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("two_link_leg_inverse_kinematics_test: done, errors");
      $finish;
    end
  end

  // Drive one target; hold it until the block takes it. Push stays high on
  // return so the next target can follow with no gap.
  task automatic send_target(logic [1:0] leg, logic [15:0] fh, logic [15:0] fx);
    while (!steady && $urandom_range(99) < 20) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1;
    leg_number <= leg;
    foot_height <= fh;
    forward_offset <= fx;
    do @(posedge clk); while (full);
    board.note_target(leg, fh, fx);
    targets_sent++;
    @(negedge clk);
  endtask

  // Hold off until every queued command is back, then let the pipe settle.
  task automatic wait_drained();
    push <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  // Mostly reachable targets scaled to the link length, with some noise.
  task automatic send_random_target();
    int span;
    logic [15:0] fh, fx;
    span = 2 * board.link_len * 256 + 64;
    if ($urandom_range(9) < 7) begin
      fh = 16'($signed($urandom_range(2 * span)) - span);
      fx = 16'($signed($urandom_range(2 * span)) - span);
      if ($urandom_range(19) == 0) fh = 0;
      if ($urandom_range(19) == 0) fx = 0;
    end else begin
      fh = 16'($urandom);
      fx = 16'($urandom);
    end
    send_target(2'($urandom), fh, fx);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: zero reach, zero height, extremes, full and over reach.
    send_target(0, 0, 0);
    send_target(1, 0, 16'sd1000);
    send_target(2, 0, -16'sd1000);
    send_target(3, 16'sd2560, 0);
    send_target(0, -16'sd2560, 0);
    send_target(1, 16'sd3000, 16'sd1500);
    send_target(2, -16'sd3000, 16'sd1500);
    send_target(3, 16'sd3000, -16'sd1500);
    send_target(0, -16'sd3000, -16'sd1500);
    send_target(1, 16'sd5120, 0);
    send_target(2, 16'sh7fff, 16'sh7fff);
    send_target(3, 16'sh8000, 16'sh8000);
    send_target(0, 16'sh7fff, 16'sh8000);
    send_target(1, 16'sd1, 16'sd1);
    send_target(2, -16'sd1, 16'sd0);
    send_target(3, 16'sd4000, 16'sd3000);
    wait_drained();

    // Extreme register settings: shortest link, saturating trims.
    write_reg(tlik_pkg::CFG_LINK_LENGTH, 32'd1);
    write_reg(tlik_pkg::CFG_KNEE_MIN, 32'hFFFF_0000);
    write_reg(tlik_pkg::CFG_FEMUR_MAX, 32'h00FF_B400);
    write_reg(tlik_pkg::CFG_HIP_MID, 32'hFF00_B400);
    send_target(0, 16'sd200, 16'sd100);
    send_target(1, 16'sd0, 16'sd300);
    send_target(2, 16'sd400, -16'sd100);
    send_target(3, 16'sd10, 16'sd10);
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      // Change every register between phases; longest link in one of them.
      write_reg(tlik_pkg::CFG_LINK_LENGTH,
                phase == 2 ? 32'd63 : 32'($urandom_range(1, 63)));
      write_reg(tlik_pkg::CFG_KNEE_MIN, $urandom);
      write_reg(tlik_pkg::CFG_FEMUR_MAX, $urandom);
      write_reg(tlik_pkg::CFG_HIP_MID, $urandom);
      steady = (phase == 3);
      repeat (96) send_random_target();
      wait_drained();
    end

    steady = 0;
    $display("covered %0d targets and %0d servo commands over several link and trim settings",
             targets_sent, cmds_seen);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("two_link_leg_inverse_kinematics_test: done, clean");
    else
      $display("two_link_leg_inverse_kinematics_test: done, errors");
    $finish;
  end
endmodule
